@@ design/rational_fraction_alu_core_macros.svh @@
// Assertion macros used by the checker file of the rational fraction ALU.
`ifndef RATIONAL_FRACTION_ALU_CORE_MACROS_SVH
`define RATIONAL_FRACTION_ALU_CORE_MACROS_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define RFA_AST_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on clk, off during reset.
`define RFA_AST_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/rfa_pkg.sv @@
// Shared types and codes for the rational fraction ALU.
`default_nettype none
package rfa_pkg;

    typedef enum logic [1:0] {
        KIND_MUL = 2'd0,
        KIND_DIV = 2'd1,
        KIND_CMP = 2'd2,
        KIND_RED = 2'd3
    } kind_t;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_OVF  = 2'd1;
    localparam logic [1:0] ST_DIVZ = 2'd2;

    localparam logic [1:0] ORD_LT = 2'b11;
    localparam logic [1:0] ORD_EQ = 2'b00;
    localparam logic [1:0] ORD_GT = 2'b01;

    typedef enum logic [1:0] {
        UOP_MUL,
        UOP_DIV,
        UOP_GCD
    } uop_t;

    typedef struct packed {
        logic start;
        uop_t op;
    } unit_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_sts_t;

    typedef enum logic [2:0] {
        U_IDLE,
        U_MUL,
        U_DIV,
        U_STRIP,
        U_LOOP,
        U_SHIFT,
        U_DONE
    } ustate_t;

    typedef enum logic [3:0] {
        T_IDLE,
        T_ENTRY,
        T_MUL1,
        T_MUL2,
        T_CHECK,
        T_PREP,
        T_GCD,
        T_QN,
        T_QD,
        T_OUT
    } tstate_t;

endpackage
`default_nettype wire

@@ design/rational_fraction_alu_core.sv @@
// Rational fraction ALU top level: sequencer around one shared iterative unit.
//
// Input channel (in_valid/in_ready): kind, a_num/a_den, b_num/b_den. The
// numerators use the low WORD_BITS bits, sign-extended; the denominators use
// the low WORD_BITS-1 bits. kind selects multiply, divide, compare or reduce.
// Output channel (out_valid/out_ready): res_num/res_den in lowest terms,
// order for compare, status (ok, overflow, zero divisor or denominator).
//
// One item at a time. in_ready is high only while the sequencer is idle.
// Steps per item, all through the one shared unit:
//   two shift-add products (overflow tests and products), skipped by reduce items,
//   binary GCD, its length depending on the operand bits,
//   two restoring divisions by the GCD.
// Zero divisor or denominator items skip the unit; overflow and compare
// items finish right after the two products.
// Reset clears the sequencer and the output valid; an item in flight is dropped.
// The result sits in an output register; a stalled receiver holds the
// sequencer at its last step until that register frees.
`default_nettype none
module rational_fraction_alu_core #(
    parameter int WORD_BITS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  kind,
    input  logic [63:0] a_num,
    input  logic [62:0] a_den,
    input  logic [63:0] b_num,
    input  logic [62:0] b_den,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] res_num,
    output logic [62:0] res_den,
    output logic [1:0]  order,
    output logic [1:0]  status
);
    import rfa_pkg::*;

    localparam int W = WORD_BITS;
    localparam logic [W-1:0] WMINMAG = {1'b1, {(W-1){1'b0}}};

    // input sign/magnitude split
    logic [W-1:0] an_w, bn_w, an_mag, bn_mag;
    assign an_w   = a_num[W-1:0];
    assign bn_w   = b_num[W-1:0];
    assign an_mag = an_w[W-1] ? (~an_w + W'(1)) : an_w;
    assign bn_mag = bn_w[W-1] ? (~bn_w + W'(1)) : bn_w;

    tstate_t        state_reg, state_next;
    kind_t          kind_reg, kind_next;
    logic           a_neg_reg, a_neg_next, b_neg_reg, b_neg_next;
    logic [W-1:0]   a_mag_reg, a_mag_next, b_mag_reg, b_mag_next;
    logic [W-2:0]   ad_reg, ad_next, bd_reg, bd_next;
    logic [2*W:0]   p1_reg, p1_next, p2_reg, p2_next;
    logic           rn_neg_reg, rn_neg_next;
    logic [W-1:0]   rn_mag_reg, rn_mag_next;
    logic [W-2:0]   rd_reg, rd_next;
    logic [W-1:0]   g_reg, g_next;
    logic [1:0]     st_reg, st_next;
    logic [1:0]     ord_reg, ord_next;
    logic           launched_reg, launched_next;

    logic           out_valid_reg, out_valid_next;
    logic [63:0]    res_num_reg, res_num_next;
    logic [62:0]    res_den_reg, res_den_next;
    logic [1:0]     order_reg, order_next;
    logic [1:0]     status_reg, status_next;

    unit_ctl_t      uctl;
    unit_sts_t      usts;
    logic [W:0]     uopa;
    logic [W-1:0]   uopb;
    logic [2*W:0]   ures;

    rfa_unit #(.W(W)) u_unit (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (uctl),
        .opa   (uopa),
        .opb   (uopb),
        .sts   (usts),
        .res   (ures)
    );

    // derived flags
    logic entry_divz, a_wmin, b_wmin, p1_big, p2_big, ovf, out_free, pa, pb;
    logic rn_wmin;
    logic [W-1:0] m1;
    logic [1:0]   cmp_raw;
    logic [W-1:0] num_w;

    assign entry_divz = (ad_reg == '0) || (kind_reg != KIND_RED && bd_reg == '0)
                        || (kind_reg == KIND_DIV && b_mag_reg == '0);
    assign a_wmin  = a_neg_reg && (a_mag_reg == WMINMAG);
    assign b_wmin  = b_neg_reg && (b_mag_reg == WMINMAG);
    assign p1_big  = |p1_reg[2*W:W-1];
    assign p2_big  = |p2_reg[2*W:W-1];
    assign ovf     = (kind_reg == KIND_MUL) ? (b_wmin || p1_big || p2_big)
                                            : (a_wmin || b_wmin || p1_big || p2_big);
    assign m1      = (kind_reg == KIND_MUL) ? a_mag_reg : {1'b0, bd_reg};
    assign pa      = !a_neg_reg && (a_mag_reg != '0);
    assign pb      = !b_neg_reg && (b_mag_reg != '0);
    assign cmp_raw = (p1_reg > p2_reg) ? ORD_GT : ((p1_reg < p2_reg) ? ORD_LT : ORD_EQ);
    assign rn_wmin = rn_neg_reg && (rn_mag_reg == WMINMAG);
    assign out_free = !out_valid_reg || out_ready;
    assign num_w   = rn_neg_reg ? (~rn_mag_reg + W'(1)) : rn_mag_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            T_IDLE:  if (in_valid) state_next = T_ENTRY;
            T_ENTRY:
            begin
                if (entry_divz)
                    state_next = T_OUT;
                else if (kind_reg == KIND_RED)
                    state_next = T_PREP;
                else
                    state_next = T_MUL1;
            end
            T_MUL1:  if (usts.done) state_next = T_MUL2;
            T_MUL2:  if (usts.done) state_next = T_CHECK;
            T_CHECK:
            begin
                if (kind_reg == KIND_CMP || ovf)
                    state_next = T_OUT;
                else
                    state_next = T_PREP;
            end
            T_PREP:
            begin
                if (rn_wmin)
                    state_next = rd_reg[0] ? T_OUT : T_PREP;
                else if (rn_mag_reg == '0)
                    state_next = T_OUT;
                else
                    state_next = T_GCD;
            end
            T_GCD:   if (usts.done) state_next = T_QN;
            T_QN:    if (usts.done) state_next = T_QD;
            T_QD:    if (usts.done) state_next = T_OUT;
            T_OUT:   if (out_free) state_next = T_IDLE;
            default: state_next = T_IDLE;
        endcase
    end

    // sequencer outputs: handshake, unit command and operands
    always_comb
    begin
        in_ready   = (state_reg == T_IDLE);
        uctl.start = 1'b0;
        uctl.op    = UOP_MUL;
        uopa       = '0;
        uopb       = '0;
        unique case (state_reg)
            T_MUL1:
            begin
                uctl.start = !launched_reg;
                case (kind_reg)
                    KIND_MUL:
                    begin
                        uopa = {1'b0, b_mag_reg} + (W+1)'(1);
                        uopb = a_mag_reg;
                    end
                    KIND_DIV:
                    begin
                        uopa = {1'b0, a_mag_reg} + (W+1)'(1);
                        uopb = {1'b0, bd_reg};
                    end
                    default:
                    begin
                        uopa = {1'b0, a_mag_reg};
                        uopb = {1'b0, bd_reg};
                    end
                endcase
            end
            T_MUL2:
            begin
                uctl.start = !launched_reg;
                uopb       = {1'b0, ad_reg};
                case (kind_reg)
                    KIND_MUL: uopa = {2'b00, bd_reg} + (W+1)'(1);
                    KIND_DIV: uopa = {1'b0, b_mag_reg} + (W+1)'(1);
                    default:  uopa = {1'b0, b_mag_reg};
                endcase
            end
            T_GCD:
            begin
                uctl.start = !launched_reg;
                uctl.op    = UOP_GCD;
                uopa       = {1'b0, rn_mag_reg};
                uopb       = {1'b0, rd_reg};
            end
            T_QN:
            begin
                uctl.start = !launched_reg;
                uctl.op    = UOP_DIV;
                uopa       = {1'b0, rn_mag_reg};
                uopb       = g_reg;
            end
            T_QD:
            begin
                uctl.start = !launched_reg;
                uctl.op    = UOP_DIV;
                uopa       = {2'b00, rd_reg};
                uopb       = g_reg;
            end
            default: ;
        endcase
    end

    // datapath
    always_comb
    begin
        kind_next      = kind_reg;
        a_neg_next     = a_neg_reg;
        a_mag_next     = a_mag_reg;
        b_neg_next     = b_neg_reg;
        b_mag_next     = b_mag_reg;
        ad_next        = ad_reg;
        bd_next        = bd_reg;
        p1_next        = p1_reg;
        p2_next        = p2_reg;
        rn_neg_next    = rn_neg_reg;
        rn_mag_next    = rn_mag_reg;
        rd_next        = rd_reg;
        g_next         = g_reg;
        st_next        = st_reg;
        ord_next       = ord_reg;
        launched_next  = launched_reg;
        out_valid_next = out_valid_reg && !out_ready;
        res_num_next   = res_num_reg;
        res_den_next   = res_den_reg;
        order_next     = order_reg;
        status_next    = status_reg;

        if (uctl.start)
            launched_next = 1'b1;
        if (usts.done)
            launched_next = 1'b0;

        case (state_reg)
            T_IDLE:
            begin
                if (in_valid)
                begin
                    kind_next   = kind_t'(kind);
                    a_neg_next  = an_w[W-1];
                    a_mag_next  = an_mag;
                    b_neg_next  = bn_w[W-1];
                    b_mag_next  = bn_mag;
                    ad_next     = a_den[W-2:0];
                    bd_next     = b_den[W-2:0];
                    st_next     = ST_OK;
                    ord_next    = ORD_EQ;
                    rn_neg_next = 1'b0;
                    rn_mag_next = '0;
                    rd_next     = '0;
                end
            end
            T_ENTRY:
            begin
                if (entry_divz)
                    st_next = ST_DIVZ;
                else if (kind_reg == KIND_RED)
                begin
                    rn_neg_next = a_neg_reg;
                    rn_mag_next = a_mag_reg;
                    rd_next     = ad_reg;
                end
            end
            T_MUL1:  if (usts.done) p1_next = ures;
            T_MUL2:  if (usts.done) p2_next = ures;
            T_CHECK:
            begin
                if (kind_reg == KIND_CMP)
                begin
                    if (!pa && pb)
                        ord_next = ORD_LT;
                    else if (pa && !pb)
                        ord_next = ORD_GT;
                    else
                        ord_next = pa ? cmp_raw : (~cmp_raw + 2'd1);
                end
                else if (ovf)
                    st_next = ST_OVF;
                else
                begin
                    rn_mag_next = p1_reg[W-1:0] - m1;
                    rd_next     = p2_reg[W-2:0] - ad_reg;
                    rn_neg_next = (p1_reg[W-1:0] != m1) && (a_neg_reg != b_neg_reg);
                end
            end
            T_PREP:
            begin
                if (rn_wmin)
                begin
                    // most negative numerator: halve against an even denominator
                    if (!rd_reg[0])
                    begin
                        rn_mag_next = WMINMAG >> 1;
                        rd_next     = rd_reg >> 1;
                    end
                end
                else if (rn_mag_reg == '0)
                begin
                    rn_neg_next = 1'b0;
                    rd_next     = (W-1)'(1);
                end
            end
            T_GCD:   if (usts.done) g_next = ures[W-1:0];
            T_QN:    if (usts.done) rn_mag_next = ures[W-1:0];
            T_QD:    if (usts.done) rd_next = ures[W-2:0];
            T_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    status_next    = st_reg;
                    if (st_reg != ST_OK || kind_reg == KIND_CMP)
                    begin
                        res_num_next = '0;
                        res_den_next = '0;
                    end
                    else
                    begin
                        res_num_next = 64'($signed(num_w));
                        res_den_next = 63'(rd_reg);
                    end
                    order_next = (st_reg == ST_OK && kind_reg == KIND_CMP) ? ord_reg : ORD_EQ;
                end
            end
            default: ;
        endcase
    end

    assign out_valid = out_valid_reg;
    assign res_num   = res_num_reg;
    assign res_den   = res_den_reg;
    assign order     = order_reg;
    assign status    = status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= T_IDLE;
            launched_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            launched_reg  <= launched_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg    <= kind_next;
        a_neg_reg   <= a_neg_next;
        a_mag_reg   <= a_mag_next;
        b_neg_reg   <= b_neg_next;
        b_mag_reg   <= b_mag_next;
        ad_reg      <= ad_next;
        bd_reg      <= bd_next;
        p1_reg      <= p1_next;
        p2_reg      <= p2_next;
        rn_neg_reg  <= rn_neg_next;
        rn_mag_reg  <= rn_mag_next;
        rd_reg      <= rd_next;
        g_reg       <= g_next;
        st_reg      <= st_next;
        ord_reg     <= ord_next;
        res_num_reg <= res_num_next;
        res_den_reg <= res_den_next;
        order_reg   <= order_next;
        status_reg  <= status_next;
    end

endmodule
`default_nettype wire

@@ design/rfa_unit.sv @@
// Shared iterative unit: shift-add multiply, restoring divide, binary GCD.
`default_nettype none
module rfa_unit #(
    parameter int W = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  rfa_pkg::unit_ctl_t ctl,
    input  logic [W:0]        opa,
    input  logic [W-1:0]      opb,
    output rfa_pkg::unit_sts_t sts,
    output logic [2*W:0]      res
);
    import rfa_pkg::*;

    localparam int CW = $clog2(W + 2);

    ustate_t        state_reg, state_next;
    logic [W:0]     hi_reg, hi_next;
    logic [W:0]     lo_reg, lo_next;
    logic [W-1:0]   m_reg, m_next;
    logic [CW-1:0]  cnt_reg, cnt_next;

    logic [W+1:0]   msum;
    logic [W+1:0]   mstep;
    logic [W:0]     rtry;
    logic [W:0]     rdiff;
    logic [W-1:0]   gx, gy, gx_next, gy_next, ymx, xmy;
    logic           cnt_last;

    assign msum     = {1'b0, hi_reg} + {2'b00, m_reg};
    assign mstep    = lo_reg[0] ? msum : {1'b0, hi_reg};
    assign rtry     = {hi_reg[W-1:0], lo_reg[W-1]};
    assign rdiff    = rtry - {1'b0, m_reg};
    assign gx       = lo_reg[W-1:0];
    assign gy       = hi_reg[W-1:0];
    assign ymx      = gy - gx;
    assign xmy      = gx - gy;
    assign cnt_last = (cnt_reg == CW'(1));

    // one binary GCD step
    always_comb
    begin
        gx_next = gx;
        gy_next = gy;
        if (!gy[0])
            gy_next = gy >> 1;
        else if (!gx[0])
            gx_next = gx >> 1;
        else if (gy >= gx)
            gy_next = ymx >> 1;
        else
            gx_next = xmy >> 1;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            U_IDLE:
            begin
                if (ctl.start)
                begin
                    unique case (ctl.op)
                        UOP_MUL: state_next = U_MUL;
                        UOP_DIV: state_next = U_DIV;
                        default: state_next = U_STRIP;
                    endcase
                end
            end
            U_MUL:   if (cnt_last) state_next = U_DONE;
            U_DIV:   if (cnt_last) state_next = U_DONE;
            U_STRIP: if (lo_reg[0] || hi_reg[0]) state_next = U_LOOP;
            U_LOOP:  if (gy_next == '0) state_next = U_SHIFT;
            U_SHIFT: if (cnt_reg == '0) state_next = U_DONE;
            U_DONE:  state_next = U_IDLE;
            default: state_next = U_IDLE;
        endcase
    end

    always_comb
    begin
        sts.busy = (state_reg != U_IDLE);
        sts.done = (state_reg == U_DONE);
    end

    always_comb
    begin
        hi_next  = hi_reg;
        lo_next  = lo_reg;
        m_next   = m_reg;
        cnt_next = cnt_reg;
        case (state_reg)
            U_IDLE:
            begin
                if (ctl.start)
                begin
                    case (ctl.op)
                        UOP_MUL:
                        begin
                            hi_next  = '0;
                            lo_next  = opa;
                            m_next   = opb;
                            cnt_next = CW'(W + 1);
                        end
                        UOP_DIV:
                        begin
                            hi_next  = '0;
                            lo_next  = {1'b0, opa[W-1:0]};
                            m_next   = opb;
                            cnt_next = CW'(W);
                        end
                        default:
                        begin
                            hi_next  = {1'b0, opb};
                            lo_next  = {1'b0, opa[W-1:0]};
                            cnt_next = '0;
                        end
                    endcase
                end
            end
            U_MUL:
            begin
                hi_next  = mstep[W+1:1];
                lo_next  = {mstep[0], lo_reg[W:1]};
                cnt_next = cnt_reg - CW'(1);
            end
            U_DIV:
            begin
                hi_next  = rdiff[W] ? rtry : rdiff;
                lo_next  = {1'b0, lo_reg[W-2:0], ~rdiff[W]};
                cnt_next = cnt_reg - CW'(1);
            end
            U_STRIP:
            begin
                if (!(lo_reg[0] || hi_reg[0]))
                begin
                    lo_next  = lo_reg >> 1;
                    hi_next  = hi_reg >> 1;
                    cnt_next = cnt_reg + CW'(1);
                end
            end
            U_LOOP:
            begin
                lo_next = {1'b0, gx_next};
                hi_next = {1'b0, gy_next};
            end
            U_SHIFT:
            begin
                if (cnt_reg != '0)
                begin
                    lo_next  = lo_reg << 1;
                    cnt_next = cnt_reg - CW'(1);
                end
            end
            default: ;
        endcase
    end

    assign res = {hi_reg[W-1:0], lo_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= U_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hi_reg <= hi_next;
        lo_reg <= lo_next;
        m_reg  <= m_next;
    end

endmodule
`default_nettype wire

@@ design/rfa_checker.sv @@
// Port-level checks for the rational fraction ALU, bound to the top level.
`default_nettype none
`include "rational_fraction_alu_core_macros.svh"
module rfa_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [63:0] res_num,
    input logic [62:0] res_den,
    input logic [1:0]  order,
    input logic [1:0]  status
);
    `RFA_AST_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
    `RFA_AST_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready after accept")
    `RFA_AST_NOW(a_err_zero, out_valid && status != 2'd0, res_num == 64'd0 && res_den == 63'd0 && order == 2'd0, "error result not zero")
    `RFA_AST_NOW(a_cmp_zero, out_valid && order != 2'd0, res_num == 64'd0 && res_den == 63'd0 && status == 2'd0, "compare with value")
    `RFA_AST_NOW(a_den_zero, out_valid && status == 2'd0 && res_den == 63'd0, res_num == 64'd0, "zero denominator with value")
endmodule

bind rational_fraction_alu_core rfa_checker u_rfa_checker (.*);
`default_nettype wire

@@ tb/sv/rational_fraction_alu_core_tb.sv @@
// Self-checking testbench for the rational fraction ALU: directed table plus random items.
`default_nettype none
module rational_fraction_alu_core_tb;
    import rfa_pkg::*;

    localparam int CLK_HALF     = 4;
    localparam int N_RANDOM     = 1400;
    localparam int STALL_LIMIT  = 20000;
    localparam logic [63:0] WMIN64 = 64'h8000_0000_0000_0000;
    localparam logic [63:0] WMAX64 = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [62:0] DMAX   = {63{1'b1}};

    typedef struct packed {
        logic [63:0] num;
        logic [62:0] den;
        logic [1:0]  ord;
        logic [1:0]  st;
    } answer_t;

    typedef struct {
        kind_t       k;
        logic [63:0] an;
        logic [62:0] ad;
        logic [63:0] bn;
        logic [62:0] bd;
        bit          typed;  // expected answer written in the table
        answer_t     ans;
    } vec_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  kind = '0;
    logic [63:0] a_num = '0;
    logic [62:0] a_den = '0;
    logic [63:0] b_num = '0;
    logic [62:0] b_den = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [63:0] res_num;
    logic [62:0] res_den;
    logic [1:0]  order;
    logic [1:0]  status;

    answer_t answers_due[$];
    vec_t    table_rows[$];
    int      n_bad = 0;
    int      idle_cnt = 0;
    bit      no_idle = 1'b0;

    always #CLK_HALF clk = ~clk;

    rational_fraction_alu_core #(.WORD_BITS(64)) DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .kind(kind), .a_num(a_num), .a_den(a_den), .b_num(b_num), .b_den(b_den),
        .out_valid(out_valid), .out_ready(out_ready),
        .res_num(res_num), .res_den(res_den), .order(order), .status(status)
    );

    // Binary GCD lowest terms; a most negative numerator is halved first,
    // or left alone when the denominator is odd.
    function automatic void lowest_terms(inout bit neg, inout logic [63:0] mag,
                                         inout logic [63:0] d);
        logic [63:0] x, y, g;
        int k;
        k = 0;
        if (neg && mag == WMIN64) begin
            if (d[0])
                return;
            mag = WMIN64 >> 1;
            d = d >> 1;
        end
        if (mag == 0) begin
            neg = 1'b0;
            d = 1;
            return;
        end
        x = mag;
        y = d;
        while (!x[0] && !y[0]) begin
            x = x >> 1;
            y = y >> 1;
            k++;
        end
        do begin
            if (!y[0])      y = y >> 1;
            else if (!x[0]) x = x >> 1;
            else if (y >= x) y = (y - x) >> 1;
            else            x = (x - y) >> 1;
        end while (y > 0);
        g = x << k;
        mag = mag / g;
        d = d / g;
    endfunction

    function automatic answer_t fraction_result(kind_t k, logic [63:0] an, logic [62:0] ad_in,
                                                logic [63:0] bn, logic [62:0] bd_in);
        answer_t r;
        bit an_neg, bn_neg, rneg, pa, pb, novf, dovf;
        logic [63:0] am, bm, rm, rd, ad, bd;
        logic [127:0] p1, p2;
        int o;
        r = '0;
        o = 0;
        rneg = 1'b0;
        rm = 0;
        rd = 0;
        ad = {1'b0, ad_in};
        bd = {1'b0, bd_in};
        an_neg = an[63];
        am = an_neg ? -an : an;
        bn_neg = bn[63];
        bm = bn_neg ? -bn : bn;
        if (ad == 0 || (k != KIND_RED && bd == 0)) begin
            r.st = ST_DIVZ;
        end else if (k == KIND_MUL) begin
            novf = (bn == WMIN64) || (am != 0 && WMAX64 / am <= bm);
            dovf = WMAX64 / ad <= bd;
            if (novf || dovf) r.st = ST_OVF;
            else begin
                rm = am * bm;
                rneg = rm != 0 && (an_neg != bn_neg);
                rd = ad * bd;
                lowest_terms(rneg, rm, rd);
            end
        end else if (k == KIND_DIV) begin
            if (bm == 0) r.st = ST_DIVZ;
            else begin
                novf = (an == WMIN64) || WMAX64 / bd <= am;
                dovf = (bn == WMIN64) || WMAX64 / ad <= bm;
                if (novf || dovf) r.st = ST_OVF;
                else begin
                    rm = am * bd;
                    rneg = rm != 0 && (an_neg != bn_neg);
                    rd = ad * bm;
                    lowest_terms(rneg, rm, rd);
                end
            end
        end else if (k == KIND_CMP) begin
            pa = !an_neg && am != 0;
            pb = !bn_neg && bm != 0;
            if (!pa && pb) o = -1;
            else if (pa && !pb) o = 1;
            else begin
                p1 = {64'd0, am} * {64'd0, bd};
                p2 = {64'd0, bm} * {64'd0, ad};
                o = (p1 < p2) ? -1 : (p1 > p2) ? 1 : 0;
                if (!pa) o = -o;
            end
        end else begin
            rneg = an_neg;
            rm = am;
            rd = ad;
            lowest_terms(rneg, rm, rd);
        end
        if (r.st == ST_OK) begin
            r.num = rneg ? -rm : rm;
            r.den = rd[62:0];
            r.ord = (o < 0) ? ORD_LT : (o > 0) ? ORD_GT : ORD_EQ;
        end
        return r;
    endfunction

    function automatic answer_t ans(logic [63:0] n, logic [62:0] d, logic [1:0] o,
                                    logic [1:0] s);
        answer_t r;
        r.num = n; r.den = d; r.ord = o; r.st = s;
        return r;
    endfunction

    task automatic add_row(kind_t k, logic [63:0] an, logic [62:0] ad, logic [63:0] bn,
                           logic [62:0] bd, bit typed = 0, answer_t a = '0);
        vec_t v;
        v.k = k; v.an = an; v.ad = ad; v.bn = bn; v.bd = bd;
        v.typed = typed; v.ans = a;
        table_rows.push_back(v);
    endtask

    // Random operand: mostly small so products stay in range, sometimes full width.
    function automatic logic [63:0] rand_num();
        case ($urandom_range(0, 9))
            0:       return {$urandom, $urandom};
            1:       return $urandom_range(0, 1) ? WMIN64 : WMAX64;
            2, 3:    return {{32{1'b0}}, $urandom} >> $urandom_range(0, 31);
            default: return 64'($signed($urandom_range(0, 4000)) - 2000) *
                            (64'd1 << $urandom_range(0, 12));
        endcase
    endfunction

    function automatic logic [62:0] rand_den();
        case ($urandom_range(0, 9))
            0:       return 63'({$urandom, $urandom});
            1:       return $urandom_range(0, 1) ? 63'd0 : DMAX;
            2, 3:    return 63'($urandom) >> $urandom_range(0, 31);
            default: return 63'($urandom_range(1, 3000)) << $urandom_range(0, 10);
        endcase
    endfunction

    // Drive one item; valid stays up with a steady payload until taken.
    task automatic send_item(kind_t k, logic [63:0] an, logic [62:0] ad, logic [63:0] bn,
                             logic [62:0] bd, bit typed, answer_t a);
        while (!no_idle && $urandom_range(0, 99) < 34) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        kind <= k;
        a_num <= an; a_den <= ad; b_num <= bn; b_den <= bd;
        answers_due.push_back(typed ? a : fraction_result(k, an, ad, bn, bd));
        do @(posedge clk); while (!in_ready);
    endtask

    // Receiver with random backpressure.
    always @(posedge clk) begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= no_idle || ($urandom_range(0, 99) >= 34);
    end

    // Compare each taken result with the oldest expectation.
    always @(posedge clk) begin
        answer_t e;
        if (rst_n && out_valid && out_ready) begin
            if (answers_due.size() == 0) begin
                n_bad++;
                if (n_bad <= 10)
                    $display("unexpected result num=%h den=%h", res_num, res_den);
            end else begin
                e = answers_due.pop_front();
                if (e.num !== res_num || e.den !== res_den || e.ord !== order
                    || e.st !== status) begin
                    n_bad++;
                    if (n_bad <= 10)
                        $display("mismatch exp num=%h den=%h ord=%0d st=%0d got num=%h den=%h ord=%0d st=%0d",
                                 e.num, e.den, e.ord, e.st, res_num, res_den, order, status);
                end
            end
        end
    end

    // Watchdog on cycles with no handshake on either side.
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cnt <= 0;
        else
            idle_cnt <= idle_cnt + 1;
        if (idle_cnt > STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        int i, wait_cyc;
        kind_t k;
        // Directed rows: the error codes and easy answers are typed in.
        add_row(KIND_MUL, 64'd3, 63'd0, 64'd1, 63'd1, 1, ans(0, 0, ORD_EQ, ST_DIVZ));
        add_row(KIND_CMP, 64'd3, 63'd1, 64'd1, 63'd0, 1, ans(0, 0, ORD_EQ, ST_DIVZ));
        add_row(KIND_RED, 64'd3, 63'd0, 64'd1, 63'd0, 1, ans(0, 0, ORD_EQ, ST_DIVZ));
        add_row(KIND_RED, 64'd5, 63'd1, 64'd1, 63'd0, 1, ans(5, 1, ORD_EQ, ST_OK));
        add_row(KIND_DIV, 64'd7, 63'd3, 64'd0, 63'd5, 1, ans(0, 0, ORD_EQ, ST_DIVZ));
        add_row(KIND_MUL, 64'd1, 63'd1, WMIN64, 63'd1, 1, ans(0, 0, ORD_EQ, ST_OVF));
        add_row(KIND_MUL, WMAX64, 63'd1, 64'd1, 63'd1, 1, ans(0, 0, ORD_EQ, ST_OVF));
        add_row(KIND_MUL, 64'd1, DMAX, 64'd1, 63'd1, 1, ans(0, 0, ORD_EQ, ST_OVF));
        add_row(KIND_DIV, WMIN64, 63'd1, 64'd1, 63'd1, 1, ans(0, 0, ORD_EQ, ST_OVF));
        add_row(KIND_DIV, 64'd1, 63'd1, WMIN64, 63'd1, 1, ans(0, 0, ORD_EQ, ST_OVF));
        add_row(KIND_RED, 64'd0, 63'd77, 64'd0, 63'd0, 1, ans(0, 1, ORD_EQ, ST_OK));
        add_row(KIND_RED, WMIN64, 63'd3, 64'd0, 63'd0, 1, ans(WMIN64, 3, ORD_EQ, ST_OK));
        add_row(KIND_RED, WMIN64, 63'd2, 64'd0, 63'd0, 1,
                ans(64'hC000_0000_0000_0000, 1, ORD_EQ, ST_OK));
        add_row(KIND_RED, WMIN64, DMAX - 63'd1, 64'd0, 63'd0);
        add_row(KIND_RED, WMAX64, DMAX, 64'd0, 63'd0, 1, ans(1, 1, ORD_EQ, ST_OK));
        add_row(KIND_RED, 64'hFFFF_FFFF_FFFF_FFFA, 63'd4, 64'd0, 63'd0);
        add_row(KIND_CMP, 64'd1, 63'd2, 64'd2, 63'd4, 1, ans(0, 0, ORD_EQ, ST_OK));
        add_row(KIND_CMP, WMIN64, 63'd1, WMAX64, DMAX, 1, ans(0, 0, ORD_LT, ST_OK));
        add_row(KIND_CMP, WMAX64, 63'd1, WMIN64, 63'd1, 1, ans(0, 0, ORD_GT, ST_OK));
        add_row(KIND_CMP, WMIN64, DMAX, WMIN64, 63'd1);
        add_row(KIND_CMP, 64'd0, 63'd5, 64'd0, 63'd9, 1, ans(0, 0, ORD_EQ, ST_OK));
        add_row(KIND_MUL, -64'd6, 63'd35, 64'd14, 63'd9);
        add_row(KIND_DIV, -64'd6, 63'd35, -64'd14, 63'd9);
        add_row(KIND_MUL, 64'd0, 63'd5, -64'd3, 63'd7, 1, ans(0, 1, ORD_EQ, ST_OK));

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (table_rows[j])
            send_item(table_rows[j].k, table_rows[j].an, table_rows[j].ad,
                      table_rows[j].bn, table_rows[j].bd, table_rows[j].typed,
                      table_rows[j].ans);

        for (i = 0; i < N_RANDOM; i++) begin
            no_idle <= (i >= 400 && i < 550);
            // hold off until every outstanding result is taken
            if (i == 700) begin
                in_valid <= 1'b0;
                while (answers_due.size() != 0) @(posedge clk);
            end
            k = kind_t'($urandom_range(0, 3));
            send_item(k, rand_num(), rand_den(), rand_num(), rand_den(), 0, '0);
        end
        in_valid <= 1'b0;

        wait_cyc = 0;
        while (answers_due.size() != 0 && wait_cyc < 200000) begin
            @(posedge clk);
            wait_cyc++;
        end
        repeat (500) @(posedge clk);
        if (n_bad == 0 && answers_due.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
`default_nettype wire

@@ sim.f @@
+incdir+design
design/rfa_pkg.sv
design/rfa_unit.sv
design/rational_fraction_alu_core.sv
design/rfa_checker.sv
tb/sv/rational_fraction_alu_core_tb.sv
